/* src/qlsf_pkg.sv */
// Shared types, constants and microcode for the quadratic least-squares fit.
// No dependencies; every other file in src imports this package.
package qlsf_pkg;

  localparam int X_BITS     = 12;
  localparam int Y_BITS     = 20;
  localparam int FRAC_BITS  = 32;
  localparam int MAX_POINTS = 4096;
  localparam int PT_BITS    = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_BITS + 1;

  localparam int SX_W   = X_BITS + PT_BITS;
  localparam int SX2_W  = 2 * X_BITS + PT_BITS;
  localparam int SX3_W  = 3 * X_BITS + PT_BITS;
  localparam int SX4_W  = 4 * X_BITS + PT_BITS;
  localparam int SY_W   = Y_BITS + PT_BITS;
  localparam int SXY_W  = X_BITS + Y_BITS + PT_BITS;
  localparam int SX2Y_W = 2 * X_BITS + Y_BITS + PT_BITS;

  localparam int WIDE_W  = 256;
  localparam int LIMB_W  = 32;
  localparam int LIMBS   = WIDE_W / LIMB_W;
  localparam int LIMB_IW = $clog2(LIMBS);
  localparam int BIT_IW  = $clog2(WIDE_W);
  localparam int ADDR_W  = 4;
  localparam int STEPS   = 14;
  localparam int STEP_IW = 4;
  localparam int COEF_W  = 64;
  localparam int PROD_W  = 2 * LIMB_W;

  localparam logic [COEF_W-1:0] POS_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] NEG_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // solver memory entries: sums occupy entries 0 to 7 (sy at A_SY), scratch entries sit above them
  localparam logic [ADDR_W-1:0] A_SY  = ADDR_W'(5);
  localparam logic [ADDR_W-1:0] A_T   = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] A_U   = ADDR_W'(9);
  localparam logic [ADDR_W-1:0] A_T0  = ADDR_W'(10);
  localparam logic [ADDR_W-1:0] A_ACC = ADDR_W'(11);

  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [X_BITS-1:0] x_value;
    logic [Y_BITS-1:0] y_value;
    logic              last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_const;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_quad;
    logic                     singular;
    logic [CNT_W-1:0]         points_used;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SX_W-1:0]   sx;
    logic [SX2_W-1:0]  sx2;
    logic [SX3_W-1:0]  sx3;
    logic [SX4_W-1:0]  sx4;
    logic [SY_W-1:0]   sy;
    logic [SXY_W-1:0]  sxy;
    logic [SX2Y_W-1:0] sx2y;
  } sums_t;

  typedef struct packed {
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic              singular;
  } coef_t;

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB} op_e;

  typedef enum logic [3:0] {
    OPD_M0, OPD_M1, OPD_M2, OPD_M3, OPD_M4, OPD_M5, OPD_M6, OPD_M7, OPD_M8,
    OPD_T, OPD_U, OPD_T0, OPD_ACC
  } opd_e;

  typedef struct packed {
    op_e  op;
    opd_e dst;
    opd_e src_a;
    opd_e src_b;
  } step_t;

  typedef enum logic [2:0] {
    T_IDLE, T_M0, T_M1, T_M2, T_M3, T_M4, T_M5, T_WAITOUT
  } top_state_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_MUL, S_MTAIL, S_DABS, S_DSET, S_DIV,
    S_SAT, S_DONE, S_SOLVE
  } sol_state_e;

  // 3x3 determinant by cofactors along the first row
  function automatic step_t step_rom(logic [STEP_IW-1:0] s);
    step_t r;
    case (s)
      4'd0:    r = step_t'{OP_MUL, OPD_T,   OPD_M4,  OPD_M8};
      4'd1:    r = step_t'{OP_MUL, OPD_U,   OPD_M5,  OPD_M7};
      4'd2:    r = step_t'{OP_SUB, OPD_T,   OPD_T,   OPD_U};
      4'd3:    r = step_t'{OP_MUL, OPD_T0,  OPD_M0,  OPD_T};
      4'd4:    r = step_t'{OP_MUL, OPD_T,   OPD_M3,  OPD_M8};
      4'd5:    r = step_t'{OP_MUL, OPD_U,   OPD_M5,  OPD_M6};
      4'd6:    r = step_t'{OP_SUB, OPD_T,   OPD_T,   OPD_U};
      4'd7:    r = step_t'{OP_MUL, OPD_T,   OPD_M1,  OPD_T};
      4'd8:    r = step_t'{OP_SUB, OPD_ACC, OPD_T0,  OPD_T};
      4'd9:    r = step_t'{OP_MUL, OPD_T,   OPD_M3,  OPD_M7};
      4'd10:   r = step_t'{OP_MUL, OPD_U,   OPD_M4,  OPD_M6};
      4'd11:   r = step_t'{OP_SUB, OPD_T,   OPD_T,   OPD_U};
      4'd12:   r = step_t'{OP_MUL, OPD_T,   OPD_M2,  OPD_T};
      4'd13:   r = step_t'{OP_ADD, OPD_ACC, OPD_ACC, OPD_T};
      default: r = step_t'{OP_ADD, OPD_ACC, OPD_ACC, OPD_T};
    endcase
    return r;
  endfunction

  // matrix element (row, col) of the normal equations sits at entry row+col;
  // determinant d > 0 swaps column d-1 for the right-hand side
  function automatic logic [ADDR_W-1:0] opd_addr(opd_e c, logic [1:0] d);
    logic [1:0]        row;
    logic [1:0]        col;
    logic              is_m;
    logic [ADDR_W-1:0] a;
    row  = 2'd0;
    col  = 2'd0;
    is_m = 1'b1;
    a    = A_T;
    case (c)
      OPD_M0:  begin row = 2'd0; col = 2'd0; end
      OPD_M1:  begin row = 2'd0; col = 2'd1; end
      OPD_M2:  begin row = 2'd0; col = 2'd2; end
      OPD_M3:  begin row = 2'd1; col = 2'd0; end
      OPD_M4:  begin row = 2'd1; col = 2'd1; end
      OPD_M5:  begin row = 2'd1; col = 2'd2; end
      OPD_M6:  begin row = 2'd2; col = 2'd0; end
      OPD_M7:  begin row = 2'd2; col = 2'd1; end
      OPD_M8:  begin row = 2'd2; col = 2'd2; end
      OPD_T:   begin is_m = 1'b0; a = A_T; end
      OPD_U:   begin is_m = 1'b0; a = A_U; end
      OPD_T0:  begin is_m = 1'b0; a = A_T0; end
      OPD_ACC: begin is_m = 1'b0; a = A_ACC; end
      default: begin is_m = 1'b0; a = A_T; end
    endcase
    if (is_m) begin
      if (d != 2'd0 && col == 2'(d - 2'd1)) begin
        a = A_SY + ADDR_W'(row);
      end else begin
        a = ADDR_W'(row) + ADDR_W'(col);
      end
    end
    return a;
  endfunction

endpackage

/* src/qlsf_if.sv */
// Valid/ready channel interfaces for sample points and fit results.
// Depends on qlsf_pkg for the beat types.
interface qlsf_in_if;
  import qlsf_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface qlsf_out_if;
  import qlsf_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* src/qlsf_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on qlsf_pkg for operand widths.
module qlsf_mul (
  input  logic                         clk_i,
  input  logic [qlsf_pkg::LIMB_W-1:0]  a_i,
  input  logic [qlsf_pkg::LIMB_W-1:0]  b_i,
  output logic [qlsf_pkg::PROD_W-1:0]  p_o
);
  import qlsf_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule

/* src/qlsf_solver.sv */
// Cramer's-rule solver: microcoded 256-bit determinants on the shared
// multiplier, then a bit-serial divide and saturation per coefficient.
// Depends on qlsf_pkg.
module qlsf_solver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  qlsf_pkg::sums_t             sums_i,
  output logic [qlsf_pkg::LIMB_W-1:0] mul_a_o,
  output logic [qlsf_pkg::LIMB_W-1:0] mul_b_o,
  input  logic [qlsf_pkg::PROD_W-1:0] prod_i,
  output logic                        done_o,
  output qlsf_pkg::coef_t             coef_o
);
  import qlsf_pkg::*;

  sol_state_e           state_q, state_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [1:0]           d_q, d_d;
  logic [STEP_IW-1:0]   s_q, s_d;
  logic [LIMB_IW-1:0]   i_q, i_d, j_q, j_d, sh_q, sh_d;
  logic                 pend_q, pend_d;
  logic [BIT_IW-1:0]    bit_q, bit_d;

  wide_t mres_q, mres_d, det_q, det_d, n_q, n_d, rem_q, rem_d;
  logic  den_neg_q, den_neg_d, num_neg_q, num_neg_d;
  coef_t coef_q, coef_d;

  wide_t             mem_q [2**ADDR_W];
  wide_t             rd_a_q, rd_b_q;
  logic              re, we;
  logic [ADDR_W-1:0] wa;
  wide_t             wd;

  step_t             st;
  logic [ADDR_W-1:0] ra, rb;
  wide_t             alu_res, mul_sum, fin_val;
  logic              fin;
  logic [LIMB_IW:0]  ij;
  logic [WIDE_W:0]   rem_sh, diff;
  logic              ge, big, neg;
  logic [COEF_W-1:0] sat;

  assign st = step_rom(s_q);
  assign ra = opd_addr(st.src_a, d_q);
  assign rb = opd_addr(st.src_b, d_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_a_q <= mem_q[ra];
      rd_b_q <= mem_q[rb];
    end
  end

  assign alu_res = (st.op == OP_ADD) ? rd_a_q + rd_b_q : rd_a_q - rd_b_q;
  assign mul_sum = mres_q + (pend_q ? (wide_t'(prod_i) << (LIMB_W * sh_q)) : '0);
  assign ij      = {1'b0, i_q} + {1'b0, j_q};
  assign rem_sh  = {rem_q, n_q[WIDE_W-1]};
  assign diff    = rem_sh - {1'b0, det_q};
  assign ge      = ~diff[WIDE_W];
  assign big     = |n_q[WIDE_W-1:COEF_W];
  assign neg     = num_neg_q ^ den_neg_q;

  always_comb begin
    if (neg) begin
      sat = (big || n_q[COEF_W-1]) ? NEG_MIN : (~n_q[COEF_W-1:0] + COEF_W'(1));
    end else begin
      sat = (big || n_q[COEF_W-1]) ? POS_MAX : n_q[COEF_W-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    d_d       = d_q;
    s_d       = s_q;
    i_d       = i_q;
    j_d       = j_q;
    sh_d      = sh_q;
    pend_d    = pend_q;
    bit_d     = bit_q;
    mres_d    = mres_q;
    det_d     = det_q;
    n_d       = n_q;
    rem_d     = rem_q;
    den_neg_d = den_neg_q;
    num_neg_d = num_neg_q;
    coef_d    = coef_q;
    re        = 1'b0;
    we        = 1'b0;
    wa        = opd_addr(st.dst, d_q);
    wd        = '0;
    fin       = 1'b0;
    fin_val   = alu_res;
    mul_a_o   = '0;
    mul_b_o   = '0;
    done_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d   = 3'd0;
          coef_d  = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        we = 1'b1;
        wa = ADDR_W'(cnt_q);
        case (cnt_q)
          3'd0:    wd = wide_t'(sums_i.count);
          3'd1:    wd = wide_t'(sums_i.sx);
          3'd2:    wd = wide_t'(sums_i.sx2);
          3'd3:    wd = wide_t'(sums_i.sx3);
          3'd4:    wd = wide_t'(sums_i.sx4);
          3'd5:    wd = wide_t'(sums_i.sy);
          3'd6:    wd = wide_t'(sums_i.sxy);
          default: wd = wide_t'(sums_i.sx2y);
        endcase
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          d_d     = 2'd0;
          s_d     = '0;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        re      = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (st.op == OP_MUL) begin
          i_d     = '0;
          j_d     = '0;
          pend_d  = 1'b0;
          mres_d  = '0;
          state_d = S_MUL;
        end else begin
          fin     = 1'b1;
          fin_val = alu_res;
        end
      end
      S_MUL: begin
        // issue one limb pair, fold in the product of the pair before
        mul_a_o = rd_a_q[LIMB_W*i_q +: LIMB_W];
        mul_b_o = rd_b_q[LIMB_W*j_q +: LIMB_W];
        mres_d  = mul_sum;
        pend_d  = 1'b1;
        sh_d    = ij[LIMB_IW-1:0];
        if (ij == (LIMB_IW+1)'(LIMBS - 1)) begin
          if (i_q == LIMB_IW'(LIMBS - 1)) begin
            state_d = S_MTAIL;
          end else begin
            i_d = i_q + LIMB_IW'(1);
            j_d = '0;
          end
        end else begin
          j_d = j_q + LIMB_IW'(1);
        end
      end
      S_MTAIL: begin
        fin     = 1'b1;
        fin_val = mul_sum;
      end
      S_DABS: begin
        den_neg_d = det_q[WIDE_W-1];
        det_d     = det_q[WIDE_W-1] ? (~det_q + wide_t'(1)) : det_q;
        if (det_q == '0) begin
          coef_d.singular = 1'b1;
          state_d         = S_DONE;
        end else begin
          d_d     = 2'd1;
          s_d     = '0;
          state_d = S_FETCH;
        end
      end
      S_DSET: begin
        num_neg_d = n_q[WIDE_W-1];
        n_d       = (n_q[WIDE_W-1] ? (~n_q + wide_t'(1)) : n_q) << FRAC_BITS;
        rem_d     = '0;
        bit_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? diff[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
        n_d   = {n_q[WIDE_W-2:0], ge};
        bit_d = bit_q + BIT_IW'(1);
        if (bit_q == BIT_IW'(WIDE_W - 1)) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        case (d_q)
          2'd1:    coef_d.c0 = sat;
          2'd2:    coef_d.c1 = sat;
          default: coef_d.c2 = sat;
        endcase
        if (d_q == 2'd3) begin
          state_d = S_DONE;
        end else begin
          d_d     = d_q + 2'd1;
          s_d     = '0;
          state_d = S_FETCH;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // write back a finished step and advance the microcode
    if (fin) begin
      we = 1'b1;
      wd = fin_val;
      if (s_q != STEP_IW'(STEPS - 1)) begin
        s_d     = s_q + STEP_IW'(1);
        state_d = S_FETCH;
      end else if (d_q == 2'd0) begin
        det_d   = fin_val;
        state_d = S_DABS;
      end else begin
        n_d     = fin_val;
        state_d = S_DSET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      d_q     <= '0;
      s_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      sh_q    <= '0;
      pend_q  <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      d_q     <= d_d;
      s_q     <= s_d;
      i_q     <= i_d;
      j_q     <= j_d;
      sh_q    <= sh_d;
      pend_q  <= pend_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mres_q    <= mres_d;
    det_q     <= det_d;
    n_q       <= n_d;
    rem_q     <= rem_d;
    den_neg_q <= den_neg_d;
    num_neg_q <= num_neg_d;
    coef_q    <= coef_d;
  end

  assign coef_o = coef_q;
endmodule

/* src/quadratic_least_squares_fit.sv */
// Top level of the quadratic least-squares fit: point accumulation,
// solver hand-off and the result register. Depends on qlsf_pkg, qlsf_if,
// qlsf_mul and qlsf_solver.
//
// For each point beat, one 32x32 multiplier, shared by the whole block,
// forms x^2, x^3, x^4, xy and x^2y in turn. A beat marked last starts the
// solve: four 3x3 determinants of 256-bit words built from 36 limb products
// per multiply on that same multiplier, then one restoring divide of 256
// steps per coefficient, skipped when the determinant is zero. Points beyond
// 4096 are ignored until the last beat. The result sits in an output
// register; points of the next data set are taken while it waits, and the
// next solve starts once it has gone.
module quadratic_least_squares_fit (
  input  logic        clk_i,
  input  logic        rst_ni,
  qlsf_in_if.sink     in_i,
  qlsf_out_if.source  out_o
);
  import qlsf_pkg::*;

  top_state_e         tstate_q, tstate_d;
  logic               solving_q, solving_d;
  sums_t              sums_q, sums_d;
  logic [X_BITS-1:0]  x_q, x_d;
  logic [Y_BITS-1:0]  y_q, y_d;
  logic               last_q, last_d;
  logic [2*X_BITS-1:0] x2_q, x2_d;
  out_beat_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [LIMB_W-1:0]  top_a, top_b, sol_a, sol_b;
  logic [PROD_W-1:0]  prod;
  logic               start, sol_done;
  coef_t              coef;

  qlsf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (solving_q ? sol_a : top_a),
    .b_i   (solving_q ? sol_b : top_b),
    .p_o   (prod)
  );

  qlsf_solver u_solver (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sums_i  (sums_q),
    .mul_a_o (sol_a),
    .mul_b_o (sol_b),
    .prod_i  (prod),
    .done_o  (sol_done),
    .coef_o  (coef)
  );

  assign in_i.ready  = (tstate_q == T_IDLE) && !solving_q;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    tstate_d    = tstate_q;
    solving_d   = solving_q;
    sums_d      = sums_q;
    x_d         = x_q;
    y_d         = y_q;
    last_d      = last_q;
    x2_d        = x2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    top_a       = '0;
    top_b       = '0;
    start       = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (tstate_q)
      T_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          x_d    = in_i.data.x_value;
          y_d    = in_i.data.y_value;
          last_d = in_i.data.last_point;
          if (sums_q.count < CNT_W'(MAX_POINTS)) begin
            tstate_d = T_M0;
          end else if (in_i.data.last_point) begin
            tstate_d = T_WAITOUT;
          end
        end
      end
      T_M0: begin
        top_a    = LIMB_W'(x_q);
        top_b    = LIMB_W'(x_q);
        tstate_d = T_M1;
      end
      T_M1: begin
        x2_d     = prod[2*X_BITS-1:0];
        top_a    = LIMB_W'(prod[2*X_BITS-1:0]);
        top_b    = LIMB_W'(x_q);
        tstate_d = T_M2;
      end
      T_M2: begin
        sums_d.sx3 = sums_q.sx3 + SX3_W'(prod);
        top_a      = LIMB_W'(x2_q);
        top_b      = LIMB_W'(x2_q);
        tstate_d   = T_M3;
      end
      T_M3: begin
        sums_d.sx4 = sums_q.sx4 + SX4_W'(prod);
        top_a      = LIMB_W'(x_q);
        top_b      = LIMB_W'(y_q);
        tstate_d   = T_M4;
      end
      T_M4: begin
        sums_d.sxy = sums_q.sxy + SXY_W'(prod);
        top_a      = LIMB_W'(x2_q);
        top_b      = LIMB_W'(y_q);
        tstate_d   = T_M5;
      end
      T_M5: begin
        sums_d.sx2y  = sums_q.sx2y + SX2Y_W'(prod);
        sums_d.sx    = sums_q.sx + SX_W'(x_q);
        sums_d.sx2   = sums_q.sx2 + SX2_W'(x2_q);
        sums_d.sy    = sums_q.sy + SY_W'(y_q);
        sums_d.count = sums_q.count + CNT_W'(1);
        tstate_d     = last_q ? T_WAITOUT : T_IDLE;
      end
      T_WAITOUT: begin
        // hold the solve until the previous result beat has gone
        if (!out_valid_q) begin
          start     = 1'b1;
          solving_d = 1'b1;
          tstate_d  = T_IDLE;
        end
      end
      default: tstate_d = T_IDLE;
    endcase

    if (solving_q && sol_done) begin
      out_d.coef_const  = $signed(coef.c0);
      out_d.coef_linear = $signed(coef.c1);
      out_d.coef_quad   = $signed(coef.c2);
      out_d.singular    = coef.singular;
      out_d.points_used = sums_q.count;
      out_valid_d       = 1'b1;
      sums_d            = '0;
      solving_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q    <= T_IDLE;
      solving_q   <= 1'b0;
      sums_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tstate_q    <= tstate_d;
      solving_q   <= solving_d;
      sums_q      <= sums_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    last_q <= last_d;
    x2_q   <= x2_d;
    out_q  <= out_d;
  end
endmodule

/* src/qlsf_checker.sv */
// Port-level checks on the fit's result channel, bound to the top level.
// Depends on qlsf_pkg and quadratic_least_squares_fit.
module qlsf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid,
  input logic                 out_ready,
  input qlsf_pkg::out_beat_t  out_data
);
  import qlsf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.singular |->
      out_data.coef_const == '0 && out_data.coef_linear == '0 &&
      out_data.coef_quad == '0)
    else $error("singular fit with nonzero coefficients");

  a_points_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.points_used != '0 &&
      out_data.points_used <= CNT_W'(MAX_POINTS))
    else $error("point count out of range");
endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
